@@ src/nhv_pkg.sv @@
`timescale 1ns / 1ps

package nhv_pkg;

   // Fixed format constants.
   localparam logic [31:0] NAV_MAGIC         = 32'hFEEDFACE;
   localparam logic [31:0] MAX_VERSION       = 32'd5;
   localparam logic [31:0] SIZE_FROM_VERSION = 32'd4;
   localparam logic [15:0] MIN_PLACE_LEN     = 16'd2;

   // Parser phases.
   localparam logic [2:0] PH_MAGIC   = 3'd0;
   localparam logic [2:0] PH_VERSION = 3'd1;
   localparam logic [2:0] PH_SIZE    = 3'd2;
   localparam logic [2:0] PH_COUNT   = 3'd3;
   localparam logic [2:0] PH_LENGTH  = 3'd4;
   localparam logic [2:0] PH_TEXT    = 3'd5;
   localparam logic [2:0] PH_AREA    = 3'd6;

   // Result status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNCATED = 3'd1;
   localparam logic [2:0] ST_INVALID   = 3'd2;
   localparam logic [2:0] ST_UNSUPP    = 3'd3;
   localparam logic [2:0] ST_LIMIT     = 3'd4;
   localparam logic [2:0] ST_TOTAL     = 3'd5;

   // Record codes.
   localparam logic REC_FILE  = 1'b0;
   localparam logic REC_DICT  = 1'b1;

   // Field codes.
   localparam logic [2:0] FLD_NONE    = 3'd0;
   localparam logic [2:0] FLD_MAGIC   = 3'd1;
   localparam logic [2:0] FLD_VERSION = 3'd2;
   localparam logic [2:0] FLD_SIZE    = 3'd3;
   localparam logic [2:0] FLD_COUNT   = 3'd4;
   localparam logic [2:0] FLD_LENGTH  = 3'd5;
   localparam logic [2:0] FLD_TEXT    = 3'd6;
   localparam logic [2:0] FLD_AREA    = 3'd7;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_PLACES      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_PLACE_BYTES = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_TOTAL_BYTES = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_AREAS       = 3'd3;

   typedef struct packed {
      logic [15:0] max_places;
      logic [15:0] max_place_bytes;
      logic [31:0] max_total_place_bytes;
      logic [31:0] max_areas;
   } nhv_cfg_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        error_record;
      logic [2:0]  error_field;
      logic [31:0] error_offset;
      logic [2:0]  format_version;
      logic [31:0] space_size;
      logic [15:0] place_total;
      logic [31:0] area_total;
      logic [31:0] header_length;
   } nhv_result_type;

   function automatic logic [2:0] field_code(input logic [2:0] phase);
      logic [2:0] code;
      case (phase)
         PH_MAGIC:   code = FLD_MAGIC;
         PH_VERSION: code = FLD_VERSION;
         PH_SIZE:    code = FLD_SIZE;
         PH_COUNT:   code = FLD_COUNT;
         PH_LENGTH:  code = FLD_LENGTH;
         PH_TEXT:    code = FLD_TEXT;
         PH_AREA:    code = FLD_AREA;
         default:    code = FLD_NONE;
      endcase
      return code;
   endfunction

   function automatic logic record_of(input logic [2:0] phase);
      return (phase == PH_COUNT || phase == PH_LENGTH || phase == PH_TEXT) ? REC_DICT
                                                                          : REC_FILE;
   endfunction

endpackage

@@ src/nav_header_validator.sv @@
`timescale 1ns / 1ps

// Navigation header checker, one byte per clock while results can drain.
// The req_ channel carries header bytes (req_action low) or an end-of-data
// mark (req_action high). Each header produces exactly one item on the rsp_
// channel: ok with the parsed version, size, place and area counts and the
// header length, or the first error found with its record, field and the
// byte offset where that field starts.
// An accepted byte sits in an input register until the parser takes it.
// A result caused by it is registered when the byte is parsed, and rsp_valid
// rises with that register. One item is taken every clock
// as long as the result register is free or being drained; the parser state
// is updated once per byte, so the rate is one byte per cycle.
// When the receiver stalls with a result pending, the input register holds
// its byte and req_ready drops until rsp_ready returns.
// Reset clears the parser to the magic field, restores the limit registers
// to their defaults and empties both registers. The csr_ port writes a limit
// register in the cycle csr_wr_en is high.
module nav_header_validator #(
   parameter int unsigned OFFSET_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic [7:0]                         req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic                               rsp_error_record,
   output logic [2:0]                         rsp_error_field,
   output logic [31:0]                        rsp_error_offset,
   output logic [2:0]                         rsp_format_version,
   output logic [31:0]                        rsp_space_size,
   output logic [15:0]                        rsp_place_total,
   output logic [31:0]                        rsp_area_total,
   output logic [31:0]                        rsp_header_length,
   input  logic                               csr_wr_en,
   input  logic [nhv_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                        csr_wdata
);
   import nhv_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic           in_action_ff;
   logic [7:0]     in_byte_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   nhv_result_type rsp_ff;

   nhv_cfg_type    cfg;
   logic           advance;
   logic           emit;
   nhv_result_type result;

   nhv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nhv_parser #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .action    (in_action_ff),
      .data_byte (in_byte_ff),
      .cfg       (cfg),
      .emit      (emit),
      .result    (result)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_data_byte;
      end
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_error_record   = rsp_ff.error_record;
   assign rsp_error_field    = rsp_ff.error_field;
   assign rsp_error_offset   = rsp_ff.error_offset;
   assign rsp_format_version = rsp_ff.format_version;
   assign rsp_space_size     = rsp_ff.space_size;
   assign rsp_place_total    = rsp_ff.place_total;
   assign rsp_area_total     = rsp_ff.area_total;
   assign rsp_header_length  = rsp_ff.header_length;

   emit_lands: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> rsp_valid_ff)
      else $error("parsed result was not registered");

   ok_has_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_OK |->
         rsp_ff.error_field == FLD_NONE && rsp_ff.error_offset == 32'd0)
      else $error("ok result carries error information");

   error_has_no_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |->
         rsp_ff.area_total == 32'd0 && rsp_ff.header_length == 32'd0)
      else $error("error result carries success totals");

endmodule

@@ src/nhv_csr.sv @@
`timescale 1ns / 1ps

module nhv_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [nhv_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [31:0]                          csr_wdata,
   output nhv_pkg::nhv_cfg_type                 cfg
);
   import nhv_pkg::*;

   nhv_cfg_type cfg_ff;
   nhv_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_MAX_PLACES:      cfg_in.max_places            = csr_wdata[15:0];
            REG_MAX_PLACE_BYTES: cfg_in.max_place_bytes       = csr_wdata[15:0];
            REG_MAX_TOTAL_BYTES: cfg_in.max_total_place_bytes = csr_wdata;
            REG_MAX_AREAS:       cfg_in.max_areas             = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_places            <= 16'd256;
         cfg_ff.max_place_bytes       <= 16'd256;
         cfg_ff.max_total_place_bytes <= 32'd65536;
         cfg_ff.max_areas             <= 32'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/nhv_parser.sv @@
`timescale 1ns / 1ps

module nhv_parser #(
   parameter int unsigned OFFSET_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic                    action,
   input  logic [7:0]              data_byte,
   input  nhv_pkg::nhv_cfg_type    cfg,
   output logic                    emit,
   output nhv_pkg::nhv_result_type result
);
   import nhv_pkg::*;

   logic [2:0]             phase_ff, phase_in;
   logic [1:0]             byte_cnt_ff, byte_cnt_in;
   logic [23:0]            shift_ff, shift_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [2:0]             version_ff, version_in;
   logic [31:0]            size_ff, size_in;
   logic [15:0]            expected_ff, expected_in;
   logic [15:0]            done_ff, done_in;
   logic [15:0]            text_left_ff, text_left_in;
   logic [31:0]            sum_ff, sum_in;
   logic                   nul_ff, nul_in;

   logic [OFFSET_BITS-1:0] pos_inc;
   logic [63:0]            start_wide;
   logic [63:0]            pos_wide;
   logic                   short_field;
   logic                   last_byte;
   logic [31:0]            value;
   logic [31:0]            total_room;

   assign pos_inc    = (pos_ff == {OFFSET_BITS{1'b1}}) ? pos_ff : pos_ff + 1'b1;
   assign start_wide = 64'(start_ff);
   assign pos_wide   = 64'(pos_inc);
   assign short_field = (phase_ff == PH_COUNT) || (phase_ff == PH_LENGTH);
   assign last_byte   = short_field ? (byte_cnt_ff == 2'd1) : (byte_cnt_ff == 2'd3);
   assign value       = short_field ? {16'd0, data_byte, shift_ff[7:0]}
                                    : {data_byte, shift_ff};
   assign total_room  = cfg.max_total_place_bytes - sum_ff;

   always_comb begin
      phase_in     = phase_ff;
      byte_cnt_in  = byte_cnt_ff;
      shift_in     = shift_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      version_in   = version_ff;
      size_in      = size_ff;
      expected_in  = expected_ff;
      done_in      = done_ff;
      text_left_in = text_left_ff;
      sum_in       = sum_ff;
      nul_in       = nul_ff;

      emit                  = 1'b0;
      result.status         = ST_OK;
      result.error_record   = REC_FILE;
      result.error_field    = FLD_NONE;
      result.error_offset   = start_wide[31:0];
      result.format_version = version_ff;
      result.space_size     = size_ff;
      result.place_total    = done_ff;
      result.area_total     = 32'd0;
      result.header_length  = 32'd0;

      if (action) begin
         emit                = 1'b1;
         result.status       = ST_TRUNCATED;
         result.error_record = record_of(phase_ff);
         result.error_field  = field_code(phase_ff);
      end else begin
         pos_in = pos_inc;
         if (phase_ff == PH_TEXT) begin
            text_left_in = text_left_ff - 16'd1;
            if (text_left_in != 16'd0) begin
               if (data_byte == 8'd0) begin
                  nul_in = 1'b1;
               end
            end else if (data_byte != 8'd0 || nul_ff) begin
               emit                = 1'b1;
               result.status       = ST_INVALID;
               result.error_record = REC_DICT;
               result.error_field  = FLD_TEXT;
            end else begin
               done_in     = done_ff + 16'd1;
               phase_in    = (done_in == expected_ff) ? PH_AREA : PH_LENGTH;
               start_in    = pos_inc;
               byte_cnt_in = 2'd0;
               shift_in    = 24'd0;
            end
         end else if (!last_byte) begin
            byte_cnt_in = byte_cnt_ff + 2'd1;
            case (byte_cnt_ff)
               2'd0:    shift_in[7:0]   = data_byte;
               2'd1:    shift_in[15:8]  = data_byte;
               2'd2:    shift_in[23:16] = data_byte;
               default: shift_in        = shift_ff;
            endcase
         end else begin
            // Field complete: a new field opens here, as it does after a text field above.
            byte_cnt_in = 2'd0;
            shift_in    = 24'd0;
            start_in    = pos_inc;
            case (phase_ff)
               PH_MAGIC: begin
                  if (value != NAV_MAGIC) begin
                     emit               = 1'b1;
                     result.status      = ST_INVALID;
                     result.error_field = FLD_MAGIC;
                  end else begin
                     phase_in = PH_VERSION;
                  end
               end
               PH_VERSION: begin
                  if (value == 32'd0 || value > MAX_VERSION) begin
                     emit               = 1'b1;
                     result.status      = ST_UNSUPP;
                     result.error_field = FLD_VERSION;
                  end else begin
                     version_in = value[2:0];
                     phase_in   = (value >= SIZE_FROM_VERSION) ? PH_SIZE : PH_AREA;
                  end
               end
               PH_SIZE: begin
                  size_in  = value;
                  phase_in = (32'(version_ff) >= MAX_VERSION) ? PH_COUNT : PH_AREA;
               end
               PH_COUNT: begin
                  if (value[15:0] > cfg.max_places) begin
                     emit                = 1'b1;
                     result.status       = ST_LIMIT;
                     result.error_record = REC_DICT;
                     result.error_field  = FLD_COUNT;
                  end else begin
                     expected_in = value[15:0];
                     done_in     = 16'd0;
                     sum_in      = 32'd0;
                     phase_in    = (value[15:0] == 16'd0) ? PH_AREA : PH_LENGTH;
                  end
               end
               PH_LENGTH: begin
                  emit                = 1'b1;
                  result.error_record = REC_DICT;
                  result.error_field  = FLD_LENGTH;
                  if (value[15:0] < MIN_PLACE_LEN) begin
                     result.status = ST_INVALID;
                  end else if (value[15:0] > cfg.max_place_bytes) begin
                     result.status = ST_LIMIT;
                  end else if (sum_ff > cfg.max_total_place_bytes ||
                               value > total_room) begin
                     // Reported against the text, at the offset of the length field.
                     result.status      = ST_TOTAL;
                     result.error_field = FLD_TEXT;
                  end else begin
                     emit         = 1'b0;
                     sum_in       = sum_ff + value;
                     phase_in     = PH_TEXT;
                     text_left_in = value[15:0];
                     nul_in       = 1'b0;
                  end
               end
               default: begin
                  emit               = 1'b1;
                  result.error_field = FLD_AREA;
                  if (value == 32'd0) begin
                     result.status = ST_INVALID;
                  end else if (value > cfg.max_areas) begin
                     result.status = ST_LIMIT;
                  end else begin
                     result.error_field   = FLD_NONE;
                     result.error_offset  = 32'd0;
                     result.area_total    = value;
                     result.header_length = pos_wide[31:0];
                  end
               end
            endcase
         end
      end

      // Every result restarts the parser at the magic field.
      if (emit) begin
         phase_in     = PH_MAGIC;
         byte_cnt_in  = 2'd0;
         shift_in     = 24'd0;
         pos_in       = '0;
         start_in     = '0;
         version_in   = 3'd0;
         size_in      = 32'd0;
         expected_in  = 16'd0;
         done_in      = 16'd0;
         text_left_in = 16'd0;
         sum_in       = 32'd0;
         nul_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         byte_cnt_ff  <= 2'd0;
         shift_ff     <= 24'd0;
         pos_ff       <= '0;
         start_ff     <= '0;
         version_ff   <= 3'd0;
         size_ff      <= 32'd0;
         expected_ff  <= 16'd0;
         done_ff      <= 16'd0;
         text_left_ff <= 16'd0;
         sum_ff       <= 32'd0;
         nul_ff       <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         byte_cnt_ff  <= byte_cnt_in;
         shift_ff     <= shift_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         version_ff   <= version_in;
         size_ff      <= size_in;
         expected_ff  <= expected_in;
         done_ff      <= done_in;
         text_left_ff <= text_left_in;
         sum_ff       <= sum_in;
         nul_ff       <= nul_in;
      end
   end

   text_left_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TEXT |-> text_left_ff != 16'd0)
      else $error("text phase entered with no bytes left");

   places_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LENGTH || phase_ff == PH_TEXT) |-> done_ff < expected_ff)
      else $error("place counter passed the expected count");

   restart_after_emit: assert property (@(posedge clock) disable iff (reset)
      step_en && emit |=> phase_ff == PH_MAGIC && pos_ff == '0 && start_ff == '0)
      else $error("parser did not restart after a result");

endmodule
